>>> rtl/ukpt_pkg.sv
// shared types and sizing constants for the uid keyed profile table
// no dependencies; used by ukpt_cell and uid_keyed_profile_table
package ukpt_pkg;

   localparam int ENTRIES      = 16;
   localparam int UID_BYTES    = 10;
   localparam int PAYLOAD_BITS = 64;

   localparam int UID_W   = UID_BYTES * 8;
   localparam int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W   = $clog2(ENTRIES + 1);
   localparam int LEN_W   = 4;
   localparam int INDEX_W = 8;
   localparam int COUNT_W = 5;

   typedef enum logic [1:0] {
      OP_ADD    = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_READ   = 2'd3
   } op_type;

   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_EXEC = 1'b1
   } state_type;

   typedef struct packed {
      logic [UID_W-1:0]        uid;
      logic [LEN_W-1:0]        len;
      logic [PAYLOAD_BITS-1:0] payload;
   } entry_type;

   // broadcast to every cell during the commit cycle
   typedef struct packed {
      logic               exec;
      op_type             op;
      logic [INDEX_W-1:0] index;
      logic [CNT_W-1:0]   count;
      logic               miss;
      entry_type          entry;
   } cmd_type;

endpackage

>>> rtl/ukpt_cell.sv
// one table slot: holds an entry, compares it against the incoming uid
// and takes its neighbour's entry on a compacting remove; uses ukpt_pkg
module ukpt_cell
   import ukpt_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic [IDX_W-1:0] slot_index,
   input  cmd_type          cmd,
   input  logic             match_prev,
   input  entry_type        next_entry,
   output logic             match_out,
   output entry_type        entry
);

   entry_type entry_ff;
   entry_type entry_in;
   logic      live;
   logic      match;
   logic      first_hit;

   assign entry = entry_ff;

   always_comb begin
      logic eq;
      eq   = 1'b1;
      live = int'(slot_index) < int'(cmd.count);
      for (int b = 0; b < UID_BYTES; b++) begin
         if (b < int'(cmd.entry.len) && entry_ff.uid[8*b +: 8] != cmd.entry.uid[8*b +: 8]) begin
            eq = 1'b0;
         end
      end
      match = live && (cmd.entry.len != '0) && (int'(cmd.entry.len) <= UID_BYTES)
              && (entry_ff.len == cmd.entry.len) && eq;
   end

   assign first_hit = match && !match_prev;
   assign match_out = match_prev || match;

   always_comb begin
      entry_in = entry_ff;
      if (cmd.exec) begin
         case (cmd.op)
            OP_ADD: begin
               if (cmd.entry.len != '0) begin
                  if (first_hit) begin
                     entry_in = cmd.entry;
                  end else if (cmd.miss && int'(slot_index) == int'(cmd.count)) begin
                     entry_in = cmd.entry;
                  end
               end
            end
            OP_REMOVE: begin
               if (int'(cmd.index) < int'(cmd.count)) begin
                  if (int'(slot_index) >= int'(cmd.index)
                      && int'(slot_index) + 1 < int'(cmd.count)) begin
                     entry_in = next_entry;
                  end else if (int'(slot_index) + 1 == int'(cmd.count)) begin
                     entry_in = '0;
                  end
               end
            end
            OP_CLEAR: begin
               entry_in = '0;
            end
            default: begin
               entry_in = entry_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_ff <= '0;
      end else begin
         entry_ff <= entry_in;
      end
   end

endmodule

>>> rtl/uid_keyed_profile_table.sv
// uid keyed profile table: a row of ENTRIES cells, one profile per cell.
// a request is captured when accepted; the response is registered when the transaction
// commits, and the commit waits while an earlier response still waits to be taken.
// a new request is accepted only in the idle state, after the capture and the commit
// of the last one, in which the match chain resolves and the cells update.
// reset (synchronous, active high) empties the table and drops any response.
module uid_keyed_profile_table
   import ukpt_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [1:0]          req_op,
   input  logic [63:0]         req_uid_low,
   input  logic [15:0]         req_uid_high,
   input  logic [3:0]          req_uid_len,
   input  logic [63:0]         req_payload,
   input  logic [7:0]          req_entry_index,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_status,
   output logic                rsp_added,
   output logic                rsp_updated,
   output logic                rsp_no_space,
   output logic                rsp_removed,
   output logic [4:0]          rsp_entry_count,
   output logic                rsp_entry_valid,
   output logic [63:0]         rsp_entry_uid_low,
   output logic [15:0]         rsp_entry_uid_high,
   output logic [3:0]          rsp_entry_uid_len,
   output logic [63:0]         rsp_entry_payload
);

   state_type state_ff, state_in;

   op_type             op_ff;
   logic [INDEX_W-1:0] index_ff;
   entry_type          req_entry_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic               rsp_valid_ff, rsp_valid_in;

   logic      accept;
   logic      commit;
   cmd_type   cmd;
   logic      match_chain [0:ENTRIES];
   entry_type entries     [0:ENTRIES-1];
   logic [UID_W+79:0] uid_wide;

   // response registers
   logic               status_ff, added_ff, updated_ff, no_space_ff, removed_ff;
   logic               entry_valid_ff;
   entry_type          read_entry_ff;
   logic               status_in, added_in, updated_in, no_space_in, removed_in;
   logic               entry_valid_in;
   entry_type          read_entry_in;

   assign accept = req_valid && req_ready;
   assign uid_wide = {{(UID_BYTES*8){1'b0}}, req_uid_high, req_uid_low};

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: if (accept) state_in = ST_EXEC;
         ST_EXEC: if (commit) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   // state outputs
   always_comb begin
      req_ready = 1'b0;
      commit    = 1'b0;
      case (state_ff)
         ST_IDLE: req_ready = 1'b1;
         ST_EXEC: commit    = !rsp_valid_ff || rsp_ready;
         default: begin
            req_ready = 1'b0;
            commit    = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // captured transaction
   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff                <= op_type'(req_op);
         index_ff             <= req_entry_index;
         req_entry_ff.uid     <= uid_wide[UID_W-1:0];
         req_entry_ff.len     <= req_uid_len;
         req_entry_ff.payload <= req_payload[PAYLOAD_BITS-1:0];
      end
   end

   assign cmd.exec  = commit;
   assign cmd.op    = op_ff;
   assign cmd.index = index_ff;
   assign cmd.count = count_ff;
   assign cmd.miss  = !match_chain[ENTRIES];
   assign cmd.entry = req_entry_ff;

   assign match_chain[0] = 1'b0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      entry_type neighbour;
      if (i == ENTRIES - 1) begin : g_last
         assign neighbour = '0;
      end else begin : g_mid
         assign neighbour = entries[i+1];
      end
      ukpt_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .slot_index (IDX_W'(i)),
         .cmd        (cmd),
         .match_prev (match_chain[i]),
         .next_entry (neighbour),
         .match_out  (match_chain[i+1]),
         .entry      (entries[i])
      );
   end

   // result of the transaction and the new count
   always_comb begin
      logic index_live;
      index_live     = int'(index_ff) < int'(count_ff);
      count_in       = count_ff;
      status_in      = 1'b0;
      added_in       = 1'b0;
      updated_in     = 1'b0;
      no_space_in    = 1'b0;
      removed_in     = 1'b0;
      entry_valid_in = 1'b0;
      read_entry_in  = '0;
      case (op_ff)
         OP_ADD: begin
            if (req_entry_ff.len == '0) begin
               status_in = 1'b1;
            end else if (match_chain[ENTRIES]) begin
               updated_in = 1'b1;
            end else if (int'(count_ff) >= ENTRIES) begin
               no_space_in = 1'b1;
            end else begin
               added_in = 1'b1;
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_REMOVE: begin
            if (index_live) begin
               removed_in = 1'b1;
               count_in   = count_ff - CNT_W'(1);
            end
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         OP_READ: begin
            if (index_live) begin
               entry_valid_in = 1'b1;
               read_entry_in  = entries[index_ff[IDX_W-1:0]];
            end
         end
         default: begin
            count_in = count_ff;
         end
      endcase
      if (!commit) begin
         count_in = count_ff;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (commit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (commit) begin
         status_ff      <= status_in;
         added_ff       <= added_in;
         updated_ff     <= updated_in;
         no_space_ff    <= no_space_in;
         removed_ff     <= removed_in;
         entry_valid_ff <= entry_valid_in;
         read_entry_ff  <= read_entry_in;
      end
   end

   logic [UID_W+79:0] read_uid_wide;
   assign read_uid_wide = {80'd0, read_entry_ff.uid};

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = status_ff;
   assign rsp_added          = added_ff;
   assign rsp_updated        = updated_ff;
   assign rsp_no_space       = no_space_ff;
   assign rsp_removed        = removed_ff;
   assign rsp_entry_count    = COUNT_W'(count_ff);
   assign rsp_entry_valid    = entry_valid_ff;
   assign rsp_entry_uid_low  = read_uid_wide[63:0];
   assign rsp_entry_uid_high = read_uid_wide[79:64];
   assign rsp_entry_uid_len  = read_entry_ff.len;
   assign rsp_entry_payload  = 64'(read_entry_ff.payload);

endmodule
